// ===== rtl/cba_pkg.sv =====
// Shared types, field widths and codes of the contiguous block allocator.
package cba_pkg;

  // Field widths of the item and result formats
  localparam int OPC_W      = 1;
  localparam int REQ_W      = 9;
  localparam int BADDR_W    = 48;
  localparam int STATUS_W   = 2;
  localparam int IDX_OUT_W  = 8;
  localparam int FREE_OUT_W = 9;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + IDX_OUT_W + BADDR_W + FREE_OUT_W);

  // Configuration port and register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int ALIGN_W    = 5;
  localparam int POOL_W     = 9;

  // Register reset values
  localparam int BSL_RESET  = 12;
  localparam int POOL_RESET = 256;

  // Bitmap word geometry and run length width
  localparam int WORD_LOG2 = 5;
  localparam int WORD_W    = 1 << WORD_LOG2;
  localparam int RUN_W     = REQ_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDR,
    CFG_ALIGN_LOG2,
    CFG_BSIZE_LOG2,
    CFG_POOL_BLOCKS
  } cfg_reg_t;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC,
    OP_FREE
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_OVER_FREE,
    STS_NO_RUN,
    STS_BAD_FREE
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_FREE_IDX,
    S_FREE_WR,
    S_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    RES_OVER_FREE,
    RES_NO_RUN,
    RES_BAD_FREE,
    RES_ZERO_LEN,
    RES_ALLOC_OK,
    RES_FREE_OK
  } res_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     take_item;
    logic     free_prep;
    logic     scan_start;
    logic     scan_step;
    logic     mark_start;
    logic     mark_step;
    logic     free_idx;
    logic     free_wr;
    logic     set_res;
    res_sel_t res_sel;
    logic     load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_free;
    logic over_free;
    logic zero_len;
    logic found;
    logic scan_last;
    logic mark_last;
    logic free_hit;
    logic out_room;
  } dp_status_t;

endpackage

// ===== rtl/contiguous_block_allocator.sv =====
// Top level of the first-fit contiguous block allocator.
//
// Usage: items arrive on the in_ stream. in_tuser selects the operation
// (allocate a run of blocks, or release one block by byte address) and
// in_tdata carries the block count and the address. Every item gives one
// result on the out_ stream: status, first block index, its byte address and
// the free block count after the item. Registers are to be written on the
// cfg_ port only while the block is idle, which the block does not enforce;
// any write frees the whole pool. A release passes through decode, block
// index and bitmap update states before its result; a request that fails
// on the free count, or asks for zero blocks, goes from decode straight to
// its result. A run search reads one 32-block bitmap word per cycle, up to
// the word where the run ends, then marks each word of the run in turn.
// One item is worked on at a time; the next is accepted as soon as the
// result sits in the output register, even if the receiver stalls it.
// While the receiver stalls with a result pending, the next result waits
// in its last state and the input stays closed after that item.
// Reset (synchronous, active low) restores the register defaults and frees
// all blocks at once; no clearing pass is needed.
module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // block_count, block_address, zero pad
  input  logic [0:0]             in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status, first_index, first_address,
                                             // free_blocks, zero pad
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ctl_cmd_t   cmd;
  dp_status_t sts;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

// ===== rtl/cba_bitmap.sv =====
// Word-wide taken-block bitmap memory with per-row valid bits.
module cba_bitmap
  import cba_pkg::*;
#(
  parameter int NUM_WORDS = 8,
  localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              rd_en,
  input  logic [WA_W-1:0]   rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [WA_W-1:0]   wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid_r;
  logic [WORD_W-1:0]    rd_word_r;
  logic                 rd_valid_r;

  // Mark rows as written; drop all of them on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (clear) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

  // A row never written reads as all free
  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// ===== rtl/cba_datapath.sv =====
// Datapath: configuration, pool geometry, bitmap scan, marking, release and result register.
module cba_datapath
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_cmd_t               cmd,
  output dp_status_t             sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W     = WA_W + WORD_LOG2;
  localparam int WIDE_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int CMP_W     = (REQ_W > CNT_W) ? REQ_W : CNT_W;
  localparam int EXT_W     = (ADDR_WIDTH > BADDR_W + 1) ? ADDR_WIDTH : BADDR_W + 1;
  localparam int KW        = (ADDR_WIDTH > CNT_W) ? ADDR_WIDTH : CNT_W;
  localparam int USABLE_RST = (POOL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : POOL_RESET;

  // Configuration registers
  logic [BADDR_W-1:0]    base_r;
  logic [ALIGN_W-1:0]    align_r;
  logic [ALIGN_W-1:0]    bsl_r;
  logic [POOL_W-1:0]     pool_r;

  // Pool geometry
  logic [EXT_W-1:0]      amask;
  logic [EXT_W-1:0]      rounded;
  logic [ADDR_WIDTH-1:0] aligned_c;
  logic                  moved_c;
  logic [POOL_W-1:0]     pool_n;
  logic [CNT_W-1:0]      usable_c;
  logic [ADDR_WIDTH-1:0] aligned_r;
  logic [CNT_W-1:0]      usable_r;
  logic [CNT_W-1:0]      used_r;
  logic [CNT_W-1:0]      free_c;

  // Item registers
  opcode_t               op_r;
  logic [REQ_W-1:0]      want_r;
  logic [ADDR_WIDTH-1:0] addr_r;

  // Release path
  logic [ADDR_WIDTH-1:0] diff_r;
  logic                  ge_r;
  logic [ADDR_WIDTH-1:0] k_full;
  logic                  ok_c;
  logic [IDX_W-1:0]      k_r;
  logic                  ok_r;
  logic [WA_W-1:0]       k_word_c;
  logic [WA_W-1:0]       k_word_r;
  logic [WORD_LOG2-1:0]  k_bit;
  logic                  free_hit_c;

  // Scan path
  logic [WA_W-1:0]       ew_r;
  logic [RUN_W-1:0]      carry_r;
  logic [WA_W-1:0]       last_word_c;
  logic [WORD_W-1:0]     taken_eff;
  logic [RUN_W-1:0]      run_end [WORD_W];
  logic                  found_c;
  logic [WORD_LOG2-1:0]  hit_bit;
  logic [POS_W-1:0]      end_pos;
  logic [IDX_W-1:0]      start_c;
  logic [IDX_W-1:0]      start_r;
  logic [IDX_W-1:0]      end_r;

  // Mark path
  logic [WA_W-1:0]       mw_r;
  logic [WORD_W-1:0]     mark_mask;

  // Bitmap port
  logic                  bm_rd_en;
  logic [WA_W-1:0]       bm_rd_addr;
  logic [WORD_W-1:0]     bm_rd_data;
  logic                  bm_wr_en;
  logic [WA_W-1:0]       bm_wr_addr;
  logic [WORD_W-1:0]     bm_wr_data;

  // Result and output registers
  status_t               res_status_r;
  logic [IDX_W-1:0]      res_idx_r;
  logic                  res_addr_en_r;
  logic [ADDR_WIDTH-1:0] res_addr_c;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [IDX_OUT_W-1:0]  out_idx_r;
  logic [BADDR_W-1:0]    out_addr_r;
  logic [FREE_OUT_W-1:0] out_free_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      align_r <= '0;
      bsl_r   <= ALIGN_W'(BSL_RESET);
      pool_r  <= POOL_W'(POOL_RESET);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_ADDR:   base_r  <= cfg_wdata[BADDR_W-1:0];
        CFG_ALIGN_LOG2:  align_r <= cfg_wdata[ALIGN_W-1:0];
        CFG_BSIZE_LOG2:  bsl_r   <= cfg_wdata[ALIGN_W-1:0];
        CFG_POOL_BLOCKS: pool_r  <= cfg_wdata[POOL_W-1:0];
      endcase
    end
  end

  // Round the base up and work out the usable block count
  always_comb begin
    amask     = (EXT_W'(1) << align_r) - EXT_W'(1);
    rounded   = (EXT_W'(base_r) + amask) & ~amask;
    aligned_c = ADDR_WIDTH'(rounded);
    moved_c   = EXT_W'(aligned_c) != EXT_W'(base_r);
    pool_n    = pool_r - POOL_W'(moved_c && (pool_r != '0));
    if (32'(pool_n) > 32'(MAX_BLOCKS)) begin
      usable_c = CNT_W'(MAX_BLOCKS);
    end else begin
      usable_c = CNT_W'(pool_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aligned_r <= '0;
      usable_r  <= CNT_W'(USABLE_RST);
    end else begin
      aligned_r <= aligned_c;
      usable_r  <= usable_c;
    end
  end

  // Taken block count; any configuration write frees the whole pool
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cfg_wen) begin
      used_r <= '0;
    end else if (cmd.scan_step && found_c) begin
      used_r <= used_r + CNT_W'(want_r);
    end else if (cmd.free_wr && free_hit_c) begin
      used_r <= used_r - CNT_W'(1);
    end
  end

  assign free_c = usable_r - used_r;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_r   <= opcode_t'(in_tuser[0]);
      want_r <= in_tdata[REQ_W-1:0];
      addr_r <= ADDR_WIDTH'(in_tdata[REQ_W+BADDR_W-1:REQ_W]);
    end
  end

  // Release: offset from the base, then block index and range check
  always_ff @(posedge clk) begin
    if (cmd.free_prep) begin
      diff_r <= addr_r - aligned_r;
      ge_r   <= addr_r >= aligned_r;
    end
  end

  always_comb begin
    k_full   = diff_r >> bsl_r;
    ok_c     = ge_r && (KW'(k_full) < KW'(usable_r));
    k_word_c = WA_W'(IDX_W'(k_full) >> WORD_LOG2);
  end

  always_ff @(posedge clk) begin
    if (cmd.free_idx) begin
      k_r      <= IDX_W'(k_full);
      ok_r     <= ok_c;
      k_word_r <= k_word_c;
    end
  end

  assign k_bit      = WORD_LOG2'(k_r);
  assign free_hit_c = ok_r && bm_rd_data[k_bit];

  // Scan: blocks past the usable count count as taken
  assign last_word_c = WA_W'((usable_r - CNT_W'(1)) >> WORD_LOG2);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      taken_eff[j] = bm_rd_data[j] |
                     (WIDE_W'({ew_r, WORD_LOG2'(j)}) >= WIDE_W'(usable_r));
    end
  end

  // Free run length ending at each bit, carried in from earlier words
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      run_end[j] = carry_r + RUN_W'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (taken_eff[k]) begin
          run_end[j] = RUN_W'(j - k);
        end
      end
    end
  end

  // Lowest bit where the run reaches the request
  always_comb begin
    found_c = 1'b0;
    hit_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (run_end[j] >= RUN_W'(want_r)) begin
        found_c = 1'b1;
        hit_bit = WORD_LOG2'(j);
      end
    end
    end_pos = {ew_r, hit_bit};
    start_c = IDX_W'(WIDE_W'(end_pos) - WIDE_W'(want_r) + WIDE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ew_r    <= '0;
      carry_r <= '0;
    end else if (cmd.scan_step) begin
      ew_r    <= ew_r + WA_W'(1);
      carry_r <= run_end[WORD_W-1];
      if (found_c) begin
        start_r <= start_c;
        end_r   <= IDX_W'(end_pos);
      end
    end
  end

  // Mark: bits of the current word that fall inside the run
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      mark_mask[j] = (WIDE_W'({mw_r, WORD_LOG2'(j)}) >= WIDE_W'(start_r)) &&
                     (WIDE_W'({mw_r, WORD_LOG2'(j)}) <= WIDE_W'(end_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_start) begin
      mw_r <= WA_W'(start_r >> WORD_LOG2);
    end else if (cmd.mark_step) begin
      mw_r <= mw_r + WA_W'(1);
    end
  end

  // Bitmap read and write selection
  always_comb begin
    bm_rd_en   = cmd.scan_start | cmd.scan_step | cmd.mark_start |
                 cmd.mark_step | cmd.free_idx;
    bm_rd_addr = '0;
    if (cmd.scan_step) begin
      bm_rd_addr = ew_r + WA_W'(1);
    end else if (cmd.mark_start) begin
      bm_rd_addr = WA_W'(start_r >> WORD_LOG2);
    end else if (cmd.mark_step) begin
      bm_rd_addr = mw_r + WA_W'(1);
    end else if (cmd.free_idx) begin
      bm_rd_addr = k_word_c;
    end

    bm_wr_en   = cmd.mark_step | (cmd.free_wr & free_hit_c);
    if (cmd.mark_step) begin
      bm_wr_addr = mw_r;
      bm_wr_data = bm_rd_data | mark_mask;
    end else begin
      bm_wr_addr = k_word_r;
      bm_wr_data = bm_rd_data & ~(WORD_W'(1) << k_bit);
    end
  end

  cba_bitmap #(
    .NUM_WORDS (NUM_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_wen),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data)
  );

  // Hold the outcome of the item
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_sel)
        RES_OVER_FREE: begin
          res_status_r  <= STS_OVER_FREE;
          res_idx_r     <= '0;
          res_addr_en_r <= 1'b0;
        end
        RES_NO_RUN: begin
          res_status_r  <= STS_NO_RUN;
          res_idx_r     <= '0;
          res_addr_en_r <= 1'b0;
        end
        RES_BAD_FREE: begin
          res_status_r  <= STS_BAD_FREE;
          res_idx_r     <= '0;
          res_addr_en_r <= 1'b0;
        end
        RES_ZERO_LEN: begin
          res_status_r  <= STS_OK;
          res_idx_r     <= '0;
          res_addr_en_r <= 1'b1;
        end
        RES_ALLOC_OK: begin
          res_status_r  <= STS_OK;
          res_idx_r     <= start_r;
          res_addr_en_r <= 1'b1;
        end
        RES_FREE_OK: begin
          res_status_r  <= STS_OK;
          res_idx_r     <= k_r;
          res_addr_en_r <= 1'b1;
        end
        default: begin
          res_status_r  <= STS_OK;
          res_idx_r     <= '0;
          res_addr_en_r <= 1'b0;
        end
      endcase
    end
  end

  // Byte address of the result block
  assign res_addr_c = aligned_r + (ADDR_WIDTH'(res_idx_r) << bsl_r);

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_idx_r    <= IDX_OUT_W'(res_idx_r);
      out_addr_r   <= res_addr_en_r ? BADDR_W'(res_addr_c) : '0;
      out_free_r   <= FREE_OUT_W'(free_c);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_free_r, out_addr_r, out_idx_r, out_status_r};

  // Status to the controller
  always_comb begin
    sts.is_free   = op_r == OP_FREE;
    sts.over_free = CMP_W'(want_r) > CMP_W'(free_c);
    sts.zero_len  = want_r == '0;
    sts.found     = found_c;
    sts.scan_last = ew_r == last_word_c;
    sts.mark_last = mw_r == WA_W'(end_r >> WORD_LOG2);
    sts.free_hit  = free_hit_c;
    sts.out_room  = !out_valid_r || out_tready;
  end

endmodule

// ===== rtl/cba_ctrl.sv =====
// Controller state machine: sequences decode, scan, marking, release and result hand-off.
module cba_ctrl
  import cba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_free) begin
          cmd.free_prep = 1'b1;
          state_nxt     = S_FREE_IDX;
        end else if (sts.over_free) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_OVER_FREE;
          state_nxt   = S_DONE;
        end else if (sts.zero_len) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_ZERO_LEN;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          state_nxt = S_MARK_RD;
        end else if (sts.scan_last) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_NO_RUN;
          state_nxt   = S_DONE;
        end
      end
      S_MARK_RD: begin
        cmd.mark_start = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_sel    = RES_ALLOC_OK;
        state_nxt      = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE_IDX: begin
        cmd.free_idx = 1'b1;
        state_nxt    = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_sel = sts.free_hit ? RES_FREE_OK : RES_BAD_FREE;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_room) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== bench/tb_contiguous_block_allocator.sv =====
// Self-checking testbench of the contiguous block allocator: directed and random streams.
module tb_contiguous_block_allocator;
  import cba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_MAX   = 256;
  localparam int QUIET_MAX  = 5000;
  localparam int LONG_HOLD  = 400;
  localparam int PHASE_ITEMS = 300;

  // Result field offsets within out_tdata
  localparam int IX_LO = STATUS_W;
  localparam int AD_LO = IX_LO + IDX_OUT_W;
  localparam int FR_LO = AD_LO + BADDR_W;

  typedef struct {
    opcode_t        op;
    logic [8:0]     count;
    logic [47:0]    addr;
  } alloc_item_t;

  typedef struct {
    status_t        status;
    logic [7:0]     index;
    logic [47:0]    addr;
    logic [8:0]     free;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // block_count, block_address, zero pad
  logic [0:0]             in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, first_index, first_address, free_blocks, pad
  logic                   cfg_wen;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Predictor copy of the registers and the pool
  logic [47:0]       reg_base;
  logic [4:0]        reg_align;
  logic [4:0]        reg_bsl;
  logic [8:0]        reg_pool;
  logic [47:0]       pool_base;
  logic [POOL_MAX-1:0] taken_bits;
  int unsigned       usable_blocks;
  int unsigned       free_left;

  grant_t grant_queue[$];
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     sink_wait = 0;

  contiguous_block_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic alloc_item_t make_item(opcode_t op, int count, logic [47:0] addr);
    alloc_item_t it;
    it.op = op;
    it.count = 9'(count);
    it.addr = addr;
    return it;
  endfunction

  // Round the base up, drop a block if it moved, free the whole pool
  function automatic void pool_rebuild();
    logic [63:0] span;
    logic [63:0] rounded;
    int unsigned n;
    span = 64'd1 << reg_align;
    rounded = ({16'd0, reg_base} + span - 64'd1) & ~(span - 64'd1);
    pool_base = rounded[47:0];
    n = reg_pool;
    if (pool_base != reg_base && n > 0) n--;
    if (n > POOL_MAX) n = POOL_MAX;
    usable_blocks = n;
    free_left = n;
    taken_bits = '0;
  endfunction

  function automatic logic [47:0] block_base_addr(int unsigned k);
    logic [63:0] s;
    s = {16'd0, pool_base} + (64'(k) << reg_bsl);
    return s[47:0];
  endfunction

  // Work out the grant of one item and advance the pool state
  function automatic grant_t predict_grant(alloc_item_t it);
    grant_t g;
    int unsigned want;
    int unsigned start;
    int unsigned run;
    int unsigned i;
    logic [63:0] k;
    bit found;
    g.status = STS_OK;
    g.index = '0;
    g.addr = '0;
    if (it.op == OP_ALLOC) begin
      want = it.count;
      if (want > free_left) begin
        g.status = STS_OVER_FREE;
      end else if (want == 0) begin
        g.addr = block_base_addr(0);
      end else begin
        found = 1'b0;
        run = 0;
        start = 0;
        for (i = 0; i < usable_blocks && !found; i++) begin
          if (taken_bits[i]) begin
            run = 0;
          end else begin
            if (run == 0) start = i;
            run++;
            if (run == want) found = 1'b1;
          end
        end
        if (!found) begin
          g.status = STS_NO_RUN;
        end else begin
          for (i = 0; i < want; i++) taken_bits[start + i] = 1'b1;
          free_left -= want;
          g.index = start[7:0];
          g.addr = block_base_addr(start);
        end
      end
    end else begin
      g.status = STS_BAD_FREE;
      if (it.addr >= pool_base) begin
        k = ({16'd0, it.addr} - {16'd0, pool_base}) >> reg_bsl;
        if (k < 64'(usable_blocks) && taken_bits[k[7:0]]) begin
          taken_bits[k[7:0]] = 1'b0;
          free_left++;
          g.status = STS_OK;
          g.index = k[7:0];
          g.addr = block_base_addr(k[8:0]);
        end
      end
    end
    g.free = free_left[8:0];
    return g;
  endfunction

  // Compare one result with the oldest grant waiting
  task automatic check_grant(input logic [OUT_TDATA_W-1:0] d);
    grant_t want;
    grant_t got;
    got.status = status_t'(d[STATUS_W-1:0]);
    got.index  = d[IX_LO +: IDX_OUT_W];
    got.addr   = d[AD_LO +: BADDR_W];
    got.free   = d[FR_LO +: FREE_OUT_W];
    if (grant_queue.size() == 0) begin
      if (mismatch_count < 10)
        $display("unexpected result: status %0d index %0d addr %h free %0d",
                 got.status, got.index, got.addr, got.free);
      mismatch_count++;
    end else begin
      want = grant_queue.pop_front();
      if (got.status != want.status || got.index != want.index ||
          got.addr != want.addr || got.free != want.free) begin
        if (mismatch_count < 10)
          $display("mismatch: exp st %0d ix %0d ad %h fr %0d, got st %0d ix %0d ad %h fr %0d",
                   want.status, want.index, want.addr, want.free,
                   got.status, got.index, got.addr, got.free);
        mismatch_count++;
      end
    end
  endtask

  // Result sink: check accepted results, stall at random or on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_grant(out_tdata);
    if (hold_served != hold_requests) begin
      hold_served++;
      sink_wait = LONG_HOLD;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      sink_wait = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("contiguous_block_allocator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after an optional gap and hold it until accepted
  task automatic send_item(input alloc_item_t it);
    int gap;
    gap = 0;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= IN_TDATA_W'({it.addr, it.count});
    do @(posedge clk); while (!in_tready);
    grant_queue.insert(grant_queue.size(), predict_grant(it));
  endtask

  // Stop offering and wait for every grant to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers back to back once the block is idle
  task automatic program_pool(input logic [47:0] base, input int align, input int bsl,
                              input int pool);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_BASE_ADDR;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_ALIGN_LOG2;
    cfg_wdata <= CFG_DATA_W'(align);
    @(posedge clk);
    cfg_index <= CFG_BSIZE_LOG2;
    cfg_wdata <= CFG_DATA_W'(bsl);
    @(posedge clk);
    cfg_index <= CFG_POOL_BLOCKS;
    cfg_wdata <= CFG_DATA_W'(pool);
    @(posedge clk);
    cfg_wen <= 1'b0;
    reg_base  = base;
    reg_align = 5'(align);
    reg_bsl   = 5'(bsl);
    reg_pool  = 9'(pool);
    pool_rebuild();
  endtask

  // Reset pool: zero length, whole pool, over-free, double free, edges of the pool
  task automatic test_default_pool();
    src_idle_pct = 20;
    sink_stall_pct = 20;
    send_item(make_item(OP_ALLOC, 0, 48'h0));
    send_item(make_item(OP_ALLOC, 256, rand_addr()));
    send_item(make_item(OP_ALLOC, 1, 48'h0));
    send_item(make_item(OP_FREE, 0, 48'h0));
    send_item(make_item(OP_FREE, 511, 48'h0));
    send_item(make_item(OP_FREE, 0, 48'h0F_FFFF));
    send_item(make_item(OP_FREE, 0, 48'h10_0000));
    send_item(make_item(OP_FREE, 0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(OP_ALLOC, 2, 48'h0));
    send_item(make_item(OP_ALLOC, 1, 48'h0));
    send_item(make_item(OP_ALLOC, 511, 48'hFFFF_FFFF_FFFF));
  endtask

  // Rounded base with a lost block, wrapped base, largest block size
  task automatic test_rounded_pool();
    program_pool(48'h1001, 12, 0, 5);
    send_item(make_item(OP_FREE, 0, 48'h1FFF));
    send_item(make_item(OP_ALLOC, 4, 48'h0));
    send_item(make_item(OP_ALLOC, 0, 48'h0));
    send_item(make_item(OP_FREE, 0, 48'h2003));
    send_item(make_item(OP_FREE, 0, 48'h2004));
    send_item(make_item(OP_ALLOC, 1, 48'h0));
    // base wraps to zero and the only block is lost
    program_pool(48'hFFFF_FFFF_FFFF, 20, 24, 1);
    send_item(make_item(OP_ALLOC, 0, 48'h0));
    send_item(make_item(OP_ALLOC, 1, 48'h0));
    program_pool(48'h0, 0, 24, 256);
    send_item(make_item(OP_ALLOC, 256, 48'h0));
    send_item(make_item(OP_FREE, 0, 48'hFF_FFFF_FFFF));
  endtask

  // Hold the sink off while the source keeps offering, then pause until empty
  task automatic test_backpressure();
    int i;
    program_pool(48'h0, 0, 12, 256);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_requests++;
    for (i = 0; i < 12; i++) send_item(make_item(OP_ALLOC, $urandom_range(1, 3), rand_addr()));
    drain();
    for (i = 0; i < 12; i++)
      send_item(make_item(OP_FREE, $urandom_range(0, 511), 48'(i) << 12));
    drain();
  endtask

  // Random phases over several settings, mostly well-formed allocate and free
  task automatic test_random_phases();
    alloc_item_t it;
    int ph;
    int n;
    int r;
    int q;
    int k;
    int j;
    int start;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          program_pool(48'h0, 0, 0, 256);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          program_pool(rand_addr(), $urandom_range(0, 20), $urandom_range(0, 24),
                       $urandom_range(1, 256));
          src_idle_pct = 30;
          sink_stall_pct = 30;
        end
        2: begin
          program_pool(48'hFFFF_FFFF_FFFF, 0, 12, 256);
          src_idle_pct = 0;
          sink_stall_pct = 40;
        end
        3: begin
          program_pool(rand_addr(), $urandom_range(0, 20), $urandom_range(0, 24),
                       $urandom_range(1, 16));
          src_idle_pct = 40;
          sink_stall_pct = 0;
        end
        4: begin
          program_pool(rand_addr(), 20, 24, 256);
          src_idle_pct = 25;
          sink_stall_pct = 25;
        end
        default: begin
          program_pool(rand_addr(), 0, 20, 2);
          src_idle_pct = 20;
          sink_stall_pct = 50;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        it.count = 9'($urandom_range(0, 511));
        it.addr = rand_addr();
        r = $urandom_range(0, 99);
        // lean towards frees while the pool is nearly full
        if (r < ((free_left * 4 < usable_blocks) ? 25 : 45)) begin
          it.op = OP_ALLOC;
          q = $urandom_range(0, 99);
          if (q < 60) it.count = 9'($urandom_range(1, 4));
          else if (q < 85) it.count = 9'($urandom_range(5, 32));
          else if (q < 95) it.count = 9'($urandom_range(0, usable_blocks));
        end else if (r < 88) begin
          // release a taken block, named by any byte inside it
          it.op = OP_FREE;
          start = $urandom_range(0, POOL_MAX - 1);
          k = -1;
          for (j = 0; j < usable_blocks && k < 0; j++)
            if (taken_bits[(start + j) % usable_blocks]) k = (start + j) % usable_blocks;
          if (k >= 0)
            it.addr = block_base_addr(k) + (rand_addr() & ((48'd1 << reg_bsl) - 48'd1));
        end else if (r < 95) begin
          // release somewhere around the pool, past its end included
          it.op = OP_FREE;
          it.addr = pool_base + (rand_addr() & 48'((64'd1 << (reg_bsl + 9)) - 64'd1));
        end else begin
          it.op = opcode_t'($urandom_range(0, 1));
        end
        send_item(it);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_wen   = 1'b0;
    cfg_index = CFG_BASE_ADDR;
    cfg_wdata = '0;
    reg_base  = '0;
    reg_align = '0;
    reg_bsl   = 5'(BSL_RESET);
    reg_pool  = 9'(POOL_RESET);
    pool_rebuild();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_default_pool();
    test_rounded_pool();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && grant_queue.size() == 0) begin
      $display("contiguous_block_allocator regression: pass");
    end else begin
      $display("contiguous_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
